@@ rtl/slac_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and helpers for the set-associative LRU cache model.
// No dependencies; imported by the way selector, the top level, the checker and the testbench.
package slac_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;
	localparam int CNT_W      = 6;

	localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

	localparam logic [1:0] MODE_IGNORE = 2'd0;
	localparam logic [1:0] MODE_LOAD   = 2'd1;
	localparam logic [1:0] MODE_STORE  = 2'd2;
	localparam logic [1:0] MODE_MODIFY = 2'd3;

	typedef struct packed {
		logic        valid;
		logic [63:0] tag;
		logic [31:0] stamp;
	} way_t;

	typedef struct packed {
		logic hit;
		logic full;
	} sel_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] v, input logic en);
		logic [31:0] r;
		r = v;
		if (en && v != 32'hFFFF_FFFF) begin
			r = v + 32'd1;
		end
		return r;
	endfunction

endpackage

@@ rtl/slac_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for access requests and lookup results.
// No dependencies.
interface slac_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [63:0] address;

	modport source (output valid, output mode, output address, input ready);
	modport sink (input valid, input mode, input address, output ready);
endinterface

interface slac_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  hits_now;
	logic        missed;
	logic        evicted;
	logic [31:0] total_hits;
	logic [31:0] total_misses;
	logic [31:0] total_evictions;

	modport source (output valid, output hits_now, output missed, output evicted,
		output total_hits, output total_misses, output total_evictions, input ready);
	modport sink (input valid, input hits_now, input missed, input evicted,
		input total_hits, input total_misses, input total_evictions, output ready);
endinterface

@@ rtl/slac_ram.sv @@
`timescale 1ns / 1ps
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module slac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                       wdata,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end
endmodule

@@ rtl/slac_way_sel.sv @@
`timescale 1ns / 1ps
// Tag compare and replacement choice over one set row.
// Depends on slac_pkg.
module slac_way_sel #(
	parameter int MAX_WAYS = 8
) (
	input  slac_pkg::way_t [MAX_WAYS-1:0]           row,
	input  logic [MAX_WAYS-1:0]                     in_use,
	input  logic [63:0]                             tag,
	output slac_pkg::sel_t                          status,
	output logic [(MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)-1:0] hit_way,
	output logic [(MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)-1:0] victim
);
	import slac_pkg::*;

	localparam int WAY_W = MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1;

	logic [MAX_WAYS-1:0] match;
	logic [MAX_WAYS-1:0] free;
	logic [WAY_W-1:0]    first_free;
	logic [WAY_W-1:0]    oldest;
	logic [31:0]         oldest_stamp;

	always_comb begin
		for (int w = 0; w < MAX_WAYS; w++) begin
			match[w] = in_use[w] & row[w].valid & (row[w].tag == tag);
			free[w]  = in_use[w] & ~row[w].valid;
		end
	end

	// Lowest index wins for both the hit and the free way.
	always_comb begin
		hit_way    = '0;
		first_free = '0;
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (match[w]) begin
				hit_way = WAY_W'(w);
			end
			if (free[w]) begin
				first_free = WAY_W'(w);
			end
		end
	end

	// Strict compare keeps the first way among equal stamps.
	always_comb begin
		oldest       = '0;
		oldest_stamp = row[0].stamp;
		for (int w = 1; w < MAX_WAYS; w++) begin
			if (in_use[w] && row[w].stamp < oldest_stamp) begin
				oldest       = WAY_W'(w);
				oldest_stamp = row[w].stamp;
			end
		end
	end

	assign status.hit  = |match;
	assign status.full = ~(|free);
	assign victim      = (|free) ? first_free : oldest;
endmodule

@@ rtl/set_assoc_lru_cache_model.sv @@
`timescale 1ns / 1ps
// Top level of the set-associative LRU cache model: control, counters, set memory.
// Depends on slac_pkg, slac_if, slac_ram and slac_way_sel.
//
// Tag-only LRU cache model. Each set is one row of a single-port memory holding valid bit,
// full tag and timestamp for every way. An item passes through the transfer, the set read,
// then compare and write-back, which also loads the result register and waits while a held
// result is not taken; one item is in the block at a time. A modify item is resolved in that
// same row update, since its second access always hits the line the first one left. After
// reset a clearing pass writes every one of the 2^MAX_SET_BITS rows (64 by default), and no
// item is accepted until it ends. Configuration may be written at any time the block is idle;
// stored lines are kept and read under the new geometry.
module set_assoc_lru_cache_model #(
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAYS     = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [slac_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [slac_pkg::CFG_DATA_W-1:0] cfg_wdata,
	slac_req_if.sink                        req,
	slac_rsp_if.source                      rsp
);
	import slac_pkg::*;

	localparam int SETS  = 1 << MAX_SET_BITS;
	localparam int SET_W = MAX_SET_BITS > 0 ? MAX_SET_BITS : 1;
	localparam int WAY_W = MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1;
	localparam int ROW_W = MAX_WAYS * $bits(way_t);

	localparam logic [1:0] ST_CLEAR  = 2'd0;
	localparam logic [1:0] ST_IDLE   = 2'd1;
	localparam logic [1:0] ST_READ   = 2'd2;
	localparam logic [1:0] ST_UPDATE = 2'd3;

	logic [1:0]       state_q;
	logic [SET_W-1:0] clr_q;

	logic [2:0] set_bits_q;
	logic [3:0] ways_q;
	logic [5:0] block_bits_q;

	logic [1:0]       mode_s1;
	logic [63:0]      tag_s1;
	logic [SET_W-1:0] set_s1;

	logic [31:0] clock_q;
	logic [31:0] hit_q;
	logic [31:0] miss_q;
	logic [31:0] evict_q;

	logic        out_valid_q;
	logic [1:0]  out_hits_q;
	logic        out_missed_q;
	logic        out_evicted_q;
	logic [31:0] out_thits_q;
	logic [31:0] out_tmiss_q;
	logic [31:0] out_tevict_q;

	// Address split
	logic [3:0]       sb;
	logic [6:0]       tshift;
	logic [63:0]      tag_now;
	logic [63:0]      set_shift;
	logic [SET_W-1:0] set_mask;

	always_comb begin
		sb = ({1'b0, set_bits_q} > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : {1'b0, set_bits_q};
		tshift    = {1'b0, block_bits_q} + {3'b0, sb};
		tag_now   = tshift[6] ? 64'd0 : (req.address >> tshift[5:0]);
		set_shift = req.address >> block_bits_q;
		for (int i = 0; i < SET_W; i++) begin
			set_mask[i] = (MAX_SET_BITS > 0) && (4'(i) < sb);
		end
	end

	// Ways in use
	logic [CNT_W-1:0]    ways_ext;
	logic [CNT_W-1:0]    ways_eff;
	logic [MAX_WAYS-1:0] in_use;

	always_comb begin
		ways_ext = {2'b0, ways_q};
		if (ways_q == 4'd0) begin
			ways_eff = CNT_W'(1);
		end else if (ways_ext > CNT_W'(MAX_WAYS)) begin
			ways_eff = CNT_W'(MAX_WAYS);
		end else begin
			ways_eff = ways_ext;
		end
		for (int w = 0; w < MAX_WAYS; w++) begin
			in_use[w] = CNT_W'(w) < ways_eff;
		end
	end

	// Set memory and lookup
	logic                        ram_we;
	logic                        ram_re;
	logic [SET_W-1:0]            ram_addr;
	logic [ROW_W-1:0]            ram_wdata;
	logic [ROW_W-1:0]            ram_rdata;
	way_t [MAX_WAYS-1:0]         rd_row;
	way_t [MAX_WAYS-1:0]         wr_row;
	sel_t                        sel;
	logic [WAY_W-1:0]            hit_way;
	logic [WAY_W-1:0]            victim;

	assign rd_row = ram_rdata;

	slac_ram #(
		.WIDTH (ROW_W),
		.DEPTH (SETS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	slac_way_sel #(
		.MAX_WAYS (MAX_WAYS)
	) u_way_sel (
		.row     (rd_row),
		.in_use  (in_use),
		.tag     (tag_s1),
		.status  (sel),
		.hit_way (hit_way),
		.victim  (victim)
	);

	// Row update
	logic             active;
	logic             is_mod;
	logic             first_hit;
	logic             missed_now;
	logic             evict_now;
	logic [1:0]       hits_now;
	logic [31:0]      stamp_new;
	logic [WAY_W-1:0] wr_way;
	logic [31:0]      hit_next;
	logic [31:0]      miss_next;
	logic [31:0]      evict_next;
	logic             done;
	logic             accept;

	always_comb begin
		active     = mode_s1 != MODE_IGNORE;
		is_mod     = mode_s1 == MODE_MODIFY;
		first_hit  = active & sel.hit;
		missed_now = active & ~sel.hit;
		evict_now  = missed_now & sel.full;
		hits_now   = {1'b0, first_hit} + {1'b0, is_mod};
		stamp_new  = clock_q + (is_mod ? 32'd2 : 32'd1);
		wr_way     = sel.hit ? hit_way : victim;
		wr_row     = rd_row;
		wr_row[wr_way] = '{valid: 1'b1, tag: tag_s1, stamp: stamp_new};
		hit_next   = sat_inc(sat_inc(hit_q, first_hit), is_mod);
		miss_next  = sat_inc(miss_q, missed_now);
		evict_next = sat_inc(evict_q, evict_now);
	end

	assign done   = (state_q == ST_UPDATE) && (!out_valid_q || rsp.ready);
	assign accept = req.valid && req.ready;

	assign req.ready = state_q == ST_IDLE;
	assign ram_re    = state_q == ST_READ;
	assign ram_we    = (state_q == ST_CLEAR) || (done && active);
	assign ram_addr  = (state_q == ST_CLEAR) ? clr_q : set_s1;
	assign ram_wdata = (state_q == ST_CLEAR) ? '0 : wr_row;

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + SET_W'(1);
					if (clr_q == SET_W'(SETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= 3'd0;
			ways_q       <= 4'd1;
			block_bits_q <= 6'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SET_BITS:   set_bits_q   <= cfg_wdata[2:0];
				CFG_WAYS:       ways_q       <= cfg_wdata[3:0];
				CFG_BLOCK_BITS: block_bits_q <= cfg_wdata[5:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= req.mode;
			tag_s1  <= tag_now;
			set_s1  <= set_shift[SET_W-1:0] & set_mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q <= '0;
			hit_q   <= '0;
			miss_q  <= '0;
			evict_q <= '0;
		end else if (done) begin
			if (active) begin
				clock_q <= stamp_new;
			end
			hit_q   <= hit_next;
			miss_q  <= miss_next;
			evict_q <= evict_next;
		end
	end

	// Result register: hold until transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_hits_q    <= hits_now;
			out_missed_q  <= missed_now;
			out_evicted_q <= evict_now;
			out_thits_q   <= hit_next;
			out_tmiss_q   <= miss_next;
			out_tevict_q  <= evict_next;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.hits_now        = out_hits_q;
	assign rsp.missed          = out_missed_q;
	assign rsp.evicted         = out_evicted_q;
	assign rsp.total_hits      = out_thits_q;
	assign rsp.total_misses    = out_tmiss_q;
	assign rsp.total_evictions = out_tevict_q;

	// Checks
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_UPDATE) |=> $stable(clock_q))
		else $error("access clock moved outside a row update");

	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_CLEAR || state_q == ST_UPDATE))
		else $error("set memory written outside clear or update");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !out_valid_q)
		else $error("result presented during clearing pass");

	assert property (@(posedge clk) disable iff (!arst_n)
		(done && evict_now) |-> (missed_now && !sel.hit))
		else $error("eviction recorded on a hit");

	assert property (@(posedge clk) disable iff (!arst_n)
		(done && missed_now && is_mod) |-> (hits_now == 2'd1))
		else $error("modify miss must count exactly one hit");
endmodule

@@ dv/cache_lookup_checker.sv @@
`timescale 1ns / 1ps
// Checker for the set-associative LRU cache model: watches configuration writes and both
// channels, predicts every lookup result and compares it field by field.
// Depends on slac_pkg and slac_if.
module cache_lookup_checker #(
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAYS     = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [slac_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [slac_pkg::CFG_DATA_W-1:0] cfg_wdata,
	slac_req_if                             req,
	slac_rsp_if                             rsp,
	output int                              fail_count,
	output int                              pending
);
	import slac_pkg::*;

	localparam int LINES = (1 << MAX_SET_BITS) * MAX_WAYS;

	typedef struct packed {
		logic [1:0]  hits_now;
		logic        missed;
		logic        evicted;
		logic [31:0] total_hits;
		logic [31:0] total_misses;
		logic [31:0] total_evictions;
	} lookup_t;

	logic [2:0]  set_bits_r;
	logic [3:0]  ways_r;
	logic [5:0]  block_bits_r;
	logic        line_valid [LINES];
	logic [63:0] line_tag [LINES];
	logic [31:0] line_stamp [LINES];
	logic [31:0] access_clock;
	logic [31:0] hit_count;
	logic [31:0] miss_count;
	logic [31:0] evict_count;
	lookup_t     expected_lookups [$];

	function automatic logic [31:0] bump(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	// One access to the tag store; returns 1 on a hit.
	function automatic logic touch_line(input logic [63:0] addr, output logic replaced);
		int          sb;
		int          ways;
		int          bb;
		int          base;
		int          victim;
		int          free_way;
		int          w;
		logic [63:0] tag;
		logic [63:0] set_idx;
		sb = (set_bits_r > MAX_SET_BITS) ? MAX_SET_BITS : set_bits_r;
		ways = (ways_r == 0) ? 1 : ((ways_r > MAX_WAYS) ? MAX_WAYS : ways_r);
		bb = block_bits_r;
		tag = (bb + sb >= 64) ? 64'd0 : (addr >> (bb + sb));
		set_idx = (addr >> bb) & ((64'd1 << sb) - 64'd1);
		base = int'(set_idx) * MAX_WAYS;
		replaced = 1'b0;
		access_clock = access_clock + 32'd1;
		for (w = 0; w < ways; w++) begin
			if (line_valid[base + w] && line_tag[base + w] == tag) begin
				line_stamp[base + w] = access_clock;
				hit_count = bump(hit_count);
				return 1'b1;
			end
		end
		free_way = -1;
		for (w = 0; w < ways && free_way < 0; w++) begin
			if (!line_valid[base + w]) begin
				free_way = w;
			end
		end
		if (free_way >= 0) begin
			victim = free_way;
		end else begin
			// oldest stamp wins, first way on a tie
			victim = 0;
			for (w = 1; w < ways; w++) begin
				if (line_stamp[base + w] < line_stamp[base + victim]) begin
					victim = w;
				end
			end
			replaced = 1'b1;
			evict_count = bump(evict_count);
		end
		miss_count = bump(miss_count);
		line_valid[base + victim] = 1'b1;
		line_tag[base + victim] = tag;
		line_stamp[base + victim] = access_clock;
		return 1'b0;
	endfunction

	function automatic lookup_t predict_lookup(input logic [1:0] mode, input logic [63:0] addr);
		lookup_t r;
		logic    hit;
		logic    rep;
		r = '0;
		if (mode != MODE_IGNORE) begin
			hit = touch_line(addr, rep);
			if (hit) begin
				r.hits_now = 2'd1;
			end else begin
				r.missed = 1'b1;
			end
			r.evicted = rep;
			if (mode == MODE_MODIFY) begin
				hit = touch_line(addr, rep);
				if (hit) begin
					r.hits_now = r.hits_now + 2'd1;
				end
				if (rep) begin
					r.evicted = 1'b1;
				end
			end
		end
		r.total_hits = hit_count;
		r.total_misses = miss_count;
		r.total_evictions = evict_count;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: lookup result mismatch: %s", $time, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		lookup_t want;
		if (!arst_n) begin
			set_bits_r = '0;
			ways_r = 4'd1;
			block_bits_r = '0;
			for (int i = 0; i < LINES; i++) begin
				line_valid[i] = 1'b0;
				line_stamp[i] = '0;
			end
			access_clock = '0;
			hit_count = '0;
			miss_count = '0;
			evict_count = '0;
			expected_lookups.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SET_BITS: begin
						set_bits_r = cfg_wdata[2:0];
					end
					CFG_WAYS: begin
						ways_r = cfg_wdata[3:0];
					end
					CFG_BLOCK_BITS: begin
						block_bits_r = cfg_wdata[5:0];
					end
					default: begin
					end
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_lookups.size() == 0) begin
					report_mismatch("result transfer with no lookup outstanding");
				end else begin
					want = expected_lookups.pop_front();
					check_field("hits_now", 32'(rsp.hits_now), 32'(want.hits_now));
					check_field("missed", 32'(rsp.missed), 32'(want.missed));
					check_field("evicted", 32'(rsp.evicted), 32'(want.evicted));
					check_field("total_hits", rsp.total_hits, want.total_hits);
					check_field("total_misses", rsp.total_misses, want.total_misses);
					check_field("total_evictions", rsp.total_evictions, want.total_evictions);
				end
			end
			if (req.valid && req.ready) begin
				expected_lookups.push_back(predict_lookup(req.mode, req.address));
			end
			pending <= expected_lookups.size();
		end
	end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Top of the cache model testbench: clock, reset, configuration phases and access stimulus.
// Depends on slac_pkg, slac_if, set_assoc_lru_cache_model and cache_lookup_checker.
module testbench;
	import slac_pkg::*;

	localparam int MAX_SET_BITS     = 6;
	localparam int MAX_WAYS         = 8;
	localparam int CYCLE_LIMIT      = 800000;
	localparam int PHASES           = 10;
	localparam int RANDOM_PER_PHASE = 170;

	// index with no register behind it
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	localparam logic [5:0] PHASE_SET [PHASES] =
		'{6'd2, 6'd6, 6'd7, 6'd3, 6'd1, 6'd6, 6'h3A, 6'd0, 6'd5, 6'd4};
	localparam logic [5:0] PHASE_WAYS [PHASES] =
		'{6'd4, 6'd8, 6'd9, 6'd0, 6'd2, 6'd15, 6'h2C, 6'd8, 6'd3, 6'd1};
	localparam logic [5:0] PHASE_BLOCK [PHASES] =
		'{6'd4, 6'd6, 6'd5, 6'd2, 6'd63, 6'd58, 6'd32, 6'd0, 6'd12, 6'd1};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int                    fails;
	int                    pending;
	int                    cycles = 0;
	int                    stall_left = 0;
	bit                    stalls_on = 1'b1;
	bit                    gaps_on = 1'b1;
	int                    eff_set_bits = 0;
	int                    eff_ways = 1;
	int                    eff_block_bits = 0;

	slac_req_if req ();
	slac_rsp_if rsp ();

	set_assoc_lru_cache_model #(
		.MAX_SET_BITS(MAX_SET_BITS),
		.MAX_WAYS    (MAX_WAYS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.req      (req),
		.rsp      (rsp)
	);

	cache_lookup_checker #(
		.MAX_SET_BITS(MAX_SET_BITS),
		.MAX_WAYS    (MAX_WAYS)
	) lookup_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp),
		.fail_count(fails),
		.pending   (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(5, 40);
	endfunction

	always @(posedge clk) begin
		if (stall_left > 0) begin
			rsp.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (stalls_on && $urandom_range(0, 3) == 0) begin
			rsp.ready <= 1'b0;
			stall_left <= pick_gap();
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	function automatic logic [63:0] make_address(input logic [63:0] tag, input int set_idx);
		logic [63:0] offset;
		int          tshift;
		offset = {$urandom, $urandom} & ((64'd1 << eff_block_bits) - 64'd1);
		tshift = eff_block_bits + eff_set_bits;
		return ((tshift >= 64) ? 64'd0 : (tag << tshift)) | (64'(set_idx) << eff_block_bits)
			| offset;
	endfunction

	task automatic send_item(input logic [1:0] mode, input logic [63:0] addr);
		int gap;
		req.valid <= 1'b1;
		req.mode <= mode;
		req.address <= addr;
		do @(posedge clk); while (req.ready !== 1'b1);
		if (gaps_on) begin
			gap = pick_gap();
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// hold the sender until every lookup has its result
	task automatic drain();
		req.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic set_geometry(input logic [5:0] sb_w, input logic [5:0] ways_w,
		input logic [5:0] bb_w, input bit with_spare);
		if (with_spare) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_SPARE;
			cfg_wdata <= 6'h3F;
			@(posedge clk);
		end
		cfg_we <= 1'b1;
		cfg_index <= CFG_SET_BITS;
		cfg_wdata <= sb_w;
		@(posedge clk);
		cfg_index <= CFG_WAYS;
		cfg_wdata <= ways_w;
		@(posedge clk);
		cfg_index <= CFG_BLOCK_BITS;
		cfg_wdata <= bb_w;
		@(posedge clk);
		cfg_we <= 1'b0;
		eff_set_bits = (sb_w[2:0] > MAX_SET_BITS) ? MAX_SET_BITS : sb_w[2:0];
		eff_ways = (ways_w[3:0] == 0) ? 1 : ((ways_w[3:0] > MAX_WAYS) ? MAX_WAYS : ways_w[3:0]);
		eff_block_bits = bb_w;
	endtask

	task automatic random_item();
		int          r;
		int          nsets;
		int          set_idx;
		logic [1:0]  mode;
		logic [63:0] tag;
		logic [63:0] addr;
		case ($urandom_range(0, 9))
			0: mode = MODE_IGNORE;
			1, 2, 3: mode = MODE_LOAD;
			4, 5, 6: mode = MODE_STORE;
			default: mode = MODE_MODIFY;
		endcase
		nsets = 1 << eff_set_bits;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			addr = {$urandom, $urandom};
		end else begin
			// few tags over few sets so lines get reused and evicted
			tag = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom}
				: 64'($urandom_range(0, eff_ways + 2));
			set_idx = (r < 85) ? $urandom_range(0, ((nsets < 4) ? nsets : 4) - 1)
				: $urandom_range(0, nsets - 1);
			addr = make_address(tag, set_idx);
		end
		send_item(mode, addr);
	endtask

	initial begin
		req.valid <= 1'b0;
		req.mode <= MODE_IGNORE;
		req.address <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_SET_BITS;
		cfg_wdata <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// default geometry: one set, one way, the whole address is the tag
		send_item(MODE_LOAD, 64'd0);
		send_item(MODE_LOAD, 64'd0);
		send_item(MODE_STORE, 64'd0);
		send_item(MODE_MODIFY, 64'd0);
		send_item(MODE_IGNORE, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(MODE_LOAD, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(MODE_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(MODE_MODIFY, 64'h5555_5555_5555_5555);
		send_item(MODE_STORE, 64'hAAAA_AAAA_AAAA_AAAA);
		send_item(MODE_IGNORE, 64'd0);
		send_item(MODE_LOAD, 64'h8000_0000_0000_0000);
		send_item(MODE_STORE, 64'd1);
		send_item(MODE_MODIFY, 64'd1);

		for (int p = 0; p < PHASES; p++) begin
			drain();
			set_geometry(PHASE_SET[p], PHASE_WAYS[p], PHASE_BLOCK[p], p == 2);
			gaps_on = ($urandom_range(0, 3) != 0);
			stalls_on = ($urandom_range(0, 3) != 0);
			for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
				random_item();
				if ($urandom_range(0, 199) == 0) begin
					drain();
				end
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (fails == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
